// ===== hw/rtl/arbh_pkg.sv =====
// arbh_pkg: shared types, constants and round functions for the aes round block hash
`default_nettype none

package arbh_pkg;

  localparam int LANES       = 8;
  localparam int WORD_W      = 64;
  localparam int LANE_W      = 128;
  localparam int ACC_DEPTH   = 16;
  localparam int BUF_DEPTH   = 32;
  localparam int SHUF_ROUNDS = 12;

  typedef logic [LANE_W-1:0] lane_t;
  typedef logic [LANES-1:0][LANE_W-1:0] lanes_t;
  typedef logic [2*LANE_W-1:0] win_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_READ,
    ST_FPREP,
    ST_LENWIN,
    ST_MIXA,
    ST_MIXB,
    ST_ALIGN,
    ST_SHA,
    ST_SHB,
    ST_FOLD,
    ST_OUT,
    ST_STORE
  } state_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_MIXA,
    OP_MIXB,
    OP_SHA,
    OP_SHB,
    OP_ROT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic swap;
  } round_ctl_t;

  // seed words, little-endian view of the pi digit table
  localparam logic [63:0] SEED_WORDS [ACC_DEPTH] = '{
    64'h8D305A88A8F64332, 64'h340737E0A2983131,
    64'h1DF399228293404A, 64'hC8E6C48EA9EF8200,
    64'h37018D631E825294, 64'hC6904EF36C46E57B,
    64'h0DC5977C9BC20ACC, 64'h9170545B5B4DF8D3,
    64'hB19F97985D6D2179, 64'h5AFB8D69BA1013BD,
    64'hFBAD01BD2DD7FFC2, 64'hE967A2D6FE1A8E7B,
    64'hF9C7125F04C9A76B, 64'hCF16397B94194A92,
    64'hC1EF58282E1F8070, 64'hE67415870D923666
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
    8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
    8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
    8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
    8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
    8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
    8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
    8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
    8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
    8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
    8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
    8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
    8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
    8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
    8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
    8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
    8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
    8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
    8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
    8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
    8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
    8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
    8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
    8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
    8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
    8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
    8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
    8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
    8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
    8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
    8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
    8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
  };

  function automatic logic [7:0] xtime(logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // inverse aes round: inv shift rows, inv sub bytes, inv mix columns, key xor
  function automatic lane_t aes_dec(lane_t st, lane_t key);
    logic [7:0] t [16];
    logic [7:0] a [4];
    logic [7:0] m2 [4];
    logic [7:0] m4 [4];
    logic [7:0] m8 [4];
    lane_t res;
    for (int c = 0; c < 4; c++) begin
      for (int rr = 0; rr < 4; rr++) begin
        t[rr + 4*c] = INV_SBOX[st[8*(rr + 4*((c + 4 - rr) & 3)) +: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      for (int rr = 0; rr < 4; rr++) begin
        a[rr]  = t[4*c + rr];
        m2[rr] = xtime(a[rr]);
        m4[rr] = xtime(m2[rr]);
        m8[rr] = xtime(m4[rr]);
      end
      // x14 = m8^m4^m2, x11 = m8^m2^a, x13 = m8^m4^a, x9 = m8^a
      res[32*c +: 8] = (m8[0]^m4[0]^m2[0]) ^ (m8[1]^m2[1]^a[1]) ^
                       (m8[2]^m4[2]^a[2]) ^ (m8[3]^a[3]);
      res[32*c+8 +: 8] = (m8[0]^a[0]) ^ (m8[1]^m4[1]^m2[1]) ^
                         (m8[2]^m2[2]^a[2]) ^ (m8[3]^m4[3]^a[3]);
      res[32*c+16 +: 8] = (m8[0]^m4[0]^a[0]) ^ (m8[1]^a[1]) ^
                          (m8[2]^m4[2]^m2[2]) ^ (m8[3]^m2[3]^a[3]);
      res[32*c+24 +: 8] = (m8[0]^m2[0]^a[0]) ^ (m8[1]^m4[1]^a[1]) ^
                          (m8[2]^a[2]) ^ (m8[3]^m4[3]^m2[3]);
    end
    return res ^ key;
  endfunction

  function automatic lane_t lane_add(lane_t a, lane_t b);
    return {a[127:64] + b[127:64], a[63:0] + b[63:0]};
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/arbh_ram.sv =====
// arbh_ram: generic one-write one-read ram with registered read data
`default_nettype none

module arbh_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/arbh_round.sv =====
// arbh_round: one half of a mix or shuffle step on the eight-lane file, with rotation
`default_nettype none

module arbh_round (
  input  wire arbh_pkg::lanes_t     x,
  input  wire arbh_pkg::win_t       win,
  input  wire arbh_pkg::round_ctl_t ctl,
  output arbh_pkg::lanes_t          y
);

  arbh_pkg::lane_t  aes_st, aes_key, aes_out;
  arbh_pkg::lane_t  i1, i2, i3, i4;
  arbh_pkg::lanes_t n;
  logic             half_b, rot;

  // message windows: bytes 15..30, 0..15 / 16..31, 1..16, 16..31 / 0..15
  assign i1 = win[120 +: 128];
  assign i3 = win[8 +: 128];
  assign i2 = ctl.swap ? win[255:128] : win[127:0];
  assign i4 = ctl.swap ? win[127:0] : win[255:128];

  assign half_b  = (ctl.op == arbh_pkg::OP_MIXB) || (ctl.op == arbh_pkg::OP_SHB);
  assign rot     = half_b || (ctl.op == arbh_pkg::OP_ROT);
  assign aes_st  = half_b ? x[4] : x[0];
  assign aes_key = half_b ? x[1] : x[4];
  assign aes_out = arbh_pkg::aes_dec(aes_st, aes_key);

  always_comb begin
    n = x;
    unique case (ctl.op)
      arbh_pkg::OP_MIXA: begin
        n[0] = aes_out;
        n[6] = arbh_pkg::lane_add(x[6], i1);
        n[4] = x[4] ^ i2;
      end
      arbh_pkg::OP_MIXB: begin
        n[4] = aes_out;
        n[2] = arbh_pkg::lane_add(x[2], i3);
        n[1] = x[1] ^ i4;
      end
      arbh_pkg::OP_SHA: begin
        n[0] = aes_out;
        n[1] = arbh_pkg::lane_add(x[1], x[5]);
        n[4] = x[4] ^ x[6];
      end
      arbh_pkg::OP_SHB: begin
        n[4] = aes_out;
        n[5] = arbh_pkg::lane_add(x[5], x[6]);
        n[1] = x[1] ^ x[2];
      end
      default: begin
      end
    endcase
  end

  // rotate so the next step always sees its lanes at the same places
  always_comb begin
    for (int k = 0; k < arbh_pkg::LANES; k++) begin
      y[k] = rot ? n[(k + 1) % arbh_pkg::LANES] : n[k];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/aes_round_block_hash.sv =====
// aes_round_block_hash: streaming 64-bit block hash over inverse aes rounds
//
//   channel | dir | handshake           | payload
//   --------+-----+---------------------+-------------------------------
//   input   | in  | in_valid/in_stall   | word[64], bytes_valid[4], last
//   output  | out | out_valid/out_stall | hash[64]
//
// a non-final beat that does not close a 256-byte block is absorbed without leaving the idle state
// a beat that closes a block loads the accumulator ram into the lane file, runs
//   8 mix steps (4 buffer ram reads, two inverse aes rounds each), then writes back
// the last beat adds a mix step per buffered 32-byte lane and 12 shuffles
// one aes round unit and the single read port of each ram set the pace of these steps
// reset is synchronous; accumulators read as the seed until the first block is stored
// output stalls hold the hash register; a new hash waits for it to drain
`default_nettype none

module aes_round_block_hash (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [63:0] word,
  input  wire logic [3:0]  bytes_valid,
  input  wire logic        last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [63:0] hash
);

  arbh_pkg::state_t     state, state_next;
  arbh_pkg::lanes_t     x, round_y;
  arbh_pkg::round_ctl_t round_ctl;
  arbh_pkg::win_t       win, fprep_win;
  logic [1023:0]        x_flat;

  logic [63:0] count, count_add;
  logic        seeded, pend_last, fin;
  logic [1:0]  fin_stage;
  logic [2:0]  step, step_nx, rot;
  logic [4:0]  cnt, rd_base, rd_fin_base;
  logic [63:0] fold_p, fold_q;

  // input beat handling
  logic        accept_in, blk_done;
  logic [3:0]  n_eff;
  logic [63:0] word_m;
  logic [127:0] l1_masked;

  // ram ports
  logic        buf_we, acc_we;
  logic [4:0]  buf_waddr, buf_raddr;
  logic [63:0] buf_rdata, acc_rdata, ld_data;
  logic [3:0]  acc_addr, ld_idx;

  assign x_flat    = x;
  assign accept_in = in_valid && !in_stall;

  // non-final beats always count as eight bytes
  assign n_eff = (!last || (bytes_valid > 4'd8)) ? 4'd8 : bytes_valid;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      word_m[8*i +: 8] = (4'(i) < n_eff) ? word[8*i +: 8] : 8'h00;
    end
  end

  assign count_add = count + {60'd0, n_eff};
  assign blk_done  = (n_eff != 4'd0) && (count_add[7:0] == 8'h00);

  // residual window starts 16 bytes below the last 16-byte boundary
  assign rd_fin_base = {count[7:4], 1'b0} - 5'd2;
  assign step_nx     = (fin_stage == 2'd2) ? step + 3'd1 : step;

  // residual: high half keeps only the bytes below the tail length
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      l1_masked[8*i +: 8] = (4'(i) < count[3:0]) ? win[128 + 8*i +: 8] : 8'h00;
    end
    fprep_win = count[4] ? {win[127:0], l1_masked} : {l1_masked, 128'd0};
  end

  // buffer ram: beats written as they arrive, read four words per mix step
  assign buf_we    = accept_in && (n_eff != 4'd0);
  assign buf_waddr = count[7:3];
  assign buf_raddr = rd_base + {3'd0, cnt[1:0]};

  arbh_ram #(
    .WIDTH (arbh_pkg::WORD_W),
    .DEPTH (arbh_pkg::BUF_DEPTH)
  ) u_buf_ram (
    .clk   (clk),
    .we    (buf_we),
    .waddr (buf_waddr),
    .wdata (word_m),
    .raddr (buf_raddr),
    .rdata (buf_rdata)
  );

  // accumulator ram: loaded into the lane file, written back after each block
  assign acc_addr = cnt[3:0];
  assign acc_we   = (state == arbh_pkg::ST_STORE);
  assign ld_idx   = 4'(cnt - 5'd1);
  assign ld_data  = seeded ? arbh_pkg::SEED_WORDS[ld_idx] : acc_rdata;

  arbh_ram #(
    .WIDTH (arbh_pkg::WORD_W),
    .DEPTH (arbh_pkg::ACC_DEPTH)
  ) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (acc_addr),
    .wdata (x_flat[63:0]),
    .raddr (acc_addr),
    .rdata (acc_rdata)
  );

  arbh_round u_round (
    .x   (x),
    .win (win),
    .ctl (round_ctl),
    .y   (round_y)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      arbh_pkg::ST_IDLE: begin
        if (accept_in && (blk_done || last)) state_next = arbh_pkg::ST_LOAD;
      end
      arbh_pkg::ST_LOAD: begin
        if (cnt == 5'd16) state_next = arbh_pkg::ST_READ;
      end
      arbh_pkg::ST_READ: begin
        if (cnt == 5'd4) begin
          state_next = (fin && (fin_stage == 2'd0)) ? arbh_pkg::ST_FPREP : arbh_pkg::ST_MIXA;
        end
      end
      arbh_pkg::ST_FPREP:  state_next = arbh_pkg::ST_MIXA;
      arbh_pkg::ST_LENWIN: state_next = arbh_pkg::ST_MIXA;
      arbh_pkg::ST_MIXA:   state_next = arbh_pkg::ST_MIXB;
      arbh_pkg::ST_MIXB: begin
        if (!fin) begin
          state_next = (step == 3'd7) ? arbh_pkg::ST_STORE : arbh_pkg::ST_READ;
        end else if (fin_stage == 2'd0) begin
          state_next = arbh_pkg::ST_LENWIN;
        end else begin
          state_next = (step_nx < count[7:5]) ? arbh_pkg::ST_READ : arbh_pkg::ST_ALIGN;
        end
      end
      arbh_pkg::ST_ALIGN: begin
        if (rot == 3'd0) state_next = arbh_pkg::ST_SHA;
      end
      arbh_pkg::ST_SHA: state_next = arbh_pkg::ST_SHB;
      arbh_pkg::ST_SHB: begin
        state_next = (cnt == 5'(arbh_pkg::SHUF_ROUNDS - 1)) ? arbh_pkg::ST_FOLD
                                                            : arbh_pkg::ST_SHA;
      end
      arbh_pkg::ST_FOLD: state_next = arbh_pkg::ST_OUT;
      arbh_pkg::ST_OUT: begin
        if (!out_valid || !out_stall) state_next = arbh_pkg::ST_IDLE;
      end
      arbh_pkg::ST_STORE: begin
        if (cnt == 5'd15) state_next = pend_last ? arbh_pkg::ST_READ : arbh_pkg::ST_IDLE;
      end
      default: state_next = arbh_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall       = (state != arbh_pkg::ST_IDLE);
    round_ctl.swap = fin && (fin_stage != 2'd2);
    unique case (state)
      arbh_pkg::ST_MIXA:  round_ctl.op = arbh_pkg::OP_MIXA;
      arbh_pkg::ST_MIXB:  round_ctl.op = arbh_pkg::OP_MIXB;
      arbh_pkg::ST_SHA:   round_ctl.op = arbh_pkg::OP_SHA;
      arbh_pkg::ST_SHB:   round_ctl.op = arbh_pkg::OP_SHB;
      arbh_pkg::ST_ALIGN: round_ctl.op = (rot != 3'd0) ? arbh_pkg::OP_ROT : arbh_pkg::OP_HOLD;
      default:            round_ctl.op = arbh_pkg::OP_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= arbh_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= 64'd0;
      seeded    <= 1'b1;
      pend_last <= 1'b0;
      fin       <= 1'b0;
      fin_stage <= 2'd0;
      step      <= 3'd0;
      rot       <= 3'd0;
      cnt       <= 5'd0;
      rd_base   <= 5'd0;
      out_valid <= 1'b0;
    end else begin
      // drained hash clears unless a new one is loaded in the same cycle
      if (out_valid && !out_stall && (state != arbh_pkg::ST_OUT)) out_valid <= 1'b0;
      unique case (state)
        arbh_pkg::ST_IDLE: begin
          if (accept_in) begin
            count     <= count_add;
            pend_last <= last;
            fin       <= !blk_done;
            cnt       <= 5'd0;
            rot       <= 3'd0;
            step      <= 3'd0;
          end
        end
        arbh_pkg::ST_LOAD: begin
          if (cnt == 5'd16) begin
            cnt       <= 5'd0;
            rd_base   <= fin ? rd_fin_base : 5'd0;
            fin_stage <= 2'd0;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        arbh_pkg::ST_READ: begin
          cnt <= (cnt == 5'd4) ? 5'd0 : cnt + 5'd1;
        end
        arbh_pkg::ST_MIXB: begin
          rot <= rot + 3'd1;
          cnt <= 5'd0;
          if (!fin) begin
            step    <= step + 3'd1;
            rd_base <= {step + 3'd1, 2'b00};
          end else if (fin_stage == 2'd0) begin
            fin_stage <= 2'd1;
          end else begin
            fin_stage <= 2'd2;
            step      <= step_nx;
            rd_base   <= {step_nx, 2'b00};
          end
        end
        arbh_pkg::ST_ALIGN: begin
          if (rot != 3'd0) rot <= rot + 3'd1;
          cnt <= 5'd0;
        end
        arbh_pkg::ST_SHB: begin
          rot <= rot + 3'd1;
          cnt <= cnt + 5'd1;
        end
        arbh_pkg::ST_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            seeded    <= 1'b1;
            count     <= 64'd0;
          end
        end
        arbh_pkg::ST_STORE: begin
          if (cnt == 5'd15) begin
            seeded    <= 1'b0;
            cnt       <= 5'd0;
            fin       <= 1'b1;
            fin_stage <= 2'd0;
            step      <= 3'd0;
            rd_base   <= rd_fin_base;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // lane file, message window, fold and hash
  always_ff @(posedge clk) begin
    unique case (state)
      arbh_pkg::ST_LOAD: begin
        // words shift in from the top, word 0 ends in the low half of lane 0
        if (cnt != 5'd0) x <= arbh_pkg::lanes_t'({ld_data, x_flat[1023:64]});
      end
      arbh_pkg::ST_READ: begin
        if (cnt != 5'd0) win <= {buf_rdata, win[255:64]};
      end
      arbh_pkg::ST_FPREP:  win <= fprep_win;
      arbh_pkg::ST_LENWIN: win <= {192'd0, count};
      arbh_pkg::ST_MIXA, arbh_pkg::ST_MIXB, arbh_pkg::ST_ALIGN,
      arbh_pkg::ST_SHA, arbh_pkg::ST_SHB: begin
        x <= round_y;
      end
      arbh_pkg::ST_FOLD: begin
        // twelve shuffles leave logical lane l at place l+4
        fold_p <= (x[4][63:0] + x[6][63:0]) ^ (x[5][63:0] + x[7][63:0]);
        fold_q <= (x[0][63:0] + x[2][63:0]) ^ (x[1][63:0] + x[3][63:0]);
      end
      arbh_pkg::ST_OUT: begin
        if (!out_valid || !out_stall) hash <= fold_p + fold_q;
      end
      arbh_pkg::ST_STORE: begin
        x <= arbh_pkg::lanes_t'({x_flat[63:0], x_flat[1023:64]});
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_store_aligned: assert property (@(posedge clk) disable iff (rst)
    (state == arbh_pkg::ST_STORE) |-> (rot == 3'd0))
    else $error("lane file not aligned at write-back");

  a_fold_rot: assert property (@(posedge clk) disable iff (rst)
    (state == arbh_pkg::ST_FOLD) |-> (rot == 3'd4))
    else $error("fold reached with unexpected lane rotation");

  a_mix_pair: assert property (@(posedge clk) disable iff (rst)
    (state == arbh_pkg::ST_MIXA) |=> (state == arbh_pkg::ST_MIXB))
    else $error("mix half b did not follow half a");

  a_block_absorb: assert property (@(posedge clk) disable iff (rst)
    (accept_in && blk_done) |=> (state == arbh_pkg::ST_LOAD) && !fin)
    else $error("completed block not absorbed");
`endif

endmodule

`default_nettype wire
